@@ src/ggv_pkg.sv @@
// Shared types, constants and helpers of the grid gradient velocity block.
`default_nettype none

package ggv_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int IDX_W      = 8;
    localparam int GRID_CFG_W = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int SHIFT_FULL = 16;
    localparam int SHIFT_HALF = 17;
    localparam int GRID_MIN   = 2;
    localparam int SLOTS      = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_SIZE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_SPACING = 1'b1;

    localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RESET   = 9'd256;
    localparam logic [DATA_W-1:0]     INV_SPACING_RESET = 32'h0001_0000;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // One difference ready for scaling: sign, magnitude and halving flag.
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic              half;
    } ggv_term_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             eof;
        logic             last;
    } ggv_meta_t;

    typedef struct packed {
        ggv_term_t x;
        ggv_term_t y;
        ggv_meta_t meta;
    } ggv_pkt_t;

    // Difference a - b as sign and magnitude; the magnitude always fits DATA_W bits.
    function automatic ggv_term_t diff_term(input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b,
                                            input logic half);
        logic signed [DATA_W:0] ab;
        logic signed [DATA_W:0] ba;
        ggv_term_t              t;
        ab     = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        ba     = {b[DATA_W-1], b} - {a[DATA_W-1], a};
        t.neg  = ab[DATA_W];
        t.mag  = ab[DATA_W] ? ba[DATA_W-1:0] : ab[DATA_W-1:0];
        t.half = half;
        return t;
    endfunction

endpackage

`default_nettype wire

@@ src/ggv_cell.sv @@
// One cell of a line store chain: loads the new sample or its neighbour's value.
`default_nettype none

module ggv_cell (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic                       load_din,
    input  logic [ggv_pkg::DATA_W-1:0] din,
    input  logic [ggv_pkg::DATA_W-1:0] prev,
    output logic [ggv_pkg::DATA_W-1:0] q
);

    logic [ggv_pkg::DATA_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= load_din ? din : prev;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ src/ggv_line.sv @@
// Line store built as a chain of cells with a movable entry point.
`default_nettype none

module ggv_line #(
    parameter int DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic [$clog2(DEPTH)-1:0]   entry,
    input  logic [ggv_pkg::DATA_W-1:0] din,
    output logic [ggv_pkg::DATA_W-1:0] tap_last,
    output logic [ggv_pkg::DATA_W-1:0] tap_prev
);

    localparam int AW = $clog2(DEPTH);

    logic [ggv_pkg::DATA_W-1:0] stage_q [DEPTH];

    // A sample enters at cell DEPTH-m and leaves the far end m requests later.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ggv_pkg::DATA_W-1:0] prev;
        if (i == 0) begin : g_head
            assign prev = din;
        end else begin : g_body
            assign prev = stage_q[i-1];
        end
        ggv_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .load_din (entry == AW'(i)),
            .din      (din),
            .prev     (prev),
            .q        (stage_q[i])
        );
    end

    assign tap_last = stage_q[DEPTH-1];
    assign tap_prev = stage_q[DEPTH-2];

endmodule

`default_nettype wire

@@ src/ggv_scale.sv @@
// Scaling lane: multiply by the reciprocal spacing, then shift, round down and saturate.
`default_nettype none

module ggv_scale (
    input  logic                       aclk,
    input  logic                       load_mul,
    input  logic                       load_out,
    input  ggv_pkg::ggv_term_t         term,
    input  logic [ggv_pkg::DATA_W-1:0] inv_spacing,
    output logic [ggv_pkg::DATA_W-1:0] vel
);

    localparam int DW  = ggv_pkg::DATA_W;
    localparam int PW  = ggv_pkg::PROD_W;
    localparam int QW  = ggv_pkg::PROD_W - ggv_pkg::SHIFT_FULL;
    localparam logic [PW-1:0] BIAS_FULL = PW'((1 << ggv_pkg::SHIFT_FULL) - 1);
    localparam logic [PW-1:0] BIAS_HALF = PW'((1 << ggv_pkg::SHIFT_HALF) - 1);

    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic          half_reg;
    logic [DW-1:0] vel_reg;

    logic [PW-1:0] bias;
    logic [PW-1:0] biased;
    logic [QW-1:0] q;
    logic [DW-1:0] vel_next;

    always_ff @(posedge aclk) begin
        if (load_mul) begin
            prod_reg <= PW'(term.mag) * PW'(inv_spacing);
            neg_reg  <= term.neg;
            half_reg <= term.half;
        end
        if (load_out) begin
            vel_reg <= vel_next;
        end
    end

    // Negative values round toward minus infinity: bias the magnitude up before the shift.
    always_comb begin
        if (!neg_reg) begin
            bias = '0;
        end else if (half_reg) begin
            bias = BIAS_HALF;
        end else begin
            bias = BIAS_FULL;
        end
        biased = prod_reg + bias;
        q      = half_reg ? QW'(biased >> ggv_pkg::SHIFT_HALF)
                          : biased[PW-1:ggv_pkg::SHIFT_FULL];
        if (neg_reg) begin
            if (q >= QW'(ggv_pkg::SAT_MIN)) begin
                vel_next = ggv_pkg::SAT_MIN;
            end else begin
                vel_next = ~q[DW-1:0] + 1'b1;
            end
        end else begin
            if (q > QW'(ggv_pkg::SAT_MAX)) begin
                vel_next = ggv_pkg::SAT_MAX;
            end else begin
                vel_next = q[DW-1:0];
            end
        end
    end

    assign vel = vel_reg;

endmodule

`default_nettype wire

@@ src/grid_gradient_velocity.sv @@
// Velocity from a stream function on a square grid, by line-buffered finite differences.
//
// Usage: stream the samples of one grid in raster order on s_valid/s_ready
// (s_sample, signed Q16.16). Each result leaves on m_valid/m_ready with vel_x,
// vel_y, its grid row and column, end_of_frame on the final grid point and
// last_in_run on the last result caused by a request. The result for a point
// is given when the sample one row below it arrives; samples of the first row
// give nothing, samples of the last row also release that row's own results.
// Write grid_size (index 0) and inv_spacing (index 1) through cfg_wr_en while idle.
// Each result passes from its slot through the multiply registers to the output
// registers; further results of the same request follow one per cycle while not stalled.
// Throughput: one sample per cycle on all rows but the last while the output is not
// stalled; on the last row every sample after the first waits until the results of
// the one before have been issued, set by the single output.
// The two line stores are chains of GRID_MAX cells each; a sample leaves after
// grid_size further requests.
// Reset empties the pipeline, sets the position to row 0, column 0 and loads
// the register defaults; the line stores hold stale data until refilled.
// When the receiver stalls, the pipeline fills and then s_ready drops.
`default_nettype none

module grid_gradient_velocity #(
    parameter int GRID_MAX     = 256,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ggv_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [ggv_pkg::DATA_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ggv_pkg::DATA_W-1:0]    m_vel_x,
    output logic signed [ggv_pkg::DATA_W-1:0]    m_vel_y,
    output logic [ggv_pkg::IDX_W-1:0]            m_row_index,
    output logic [ggv_pkg::IDX_W-1:0]            m_col_index,
    output logic                                 m_end_of_frame,
    output logic                                 m_last_in_run
);

    localparam int DW = ggv_pkg::DATA_W;
    localparam int XW = ggv_pkg::IDX_W;
    localparam int GW = ggv_pkg::GRID_CFG_W;
    localparam int NS = ggv_pkg::SLOTS;
    localparam int CW = $clog2(GRID_MAX);
    localparam int MW = $clog2(GRID_MAX + 1);
    localparam int EW = (MW > GW) ? MW : GW;

    // Configuration
    logic [GW-1:0] grid_size_reg;
    logic [DW-1:0] inv_spacing_reg;

    // Position and control
    logic [CW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_next;
    logic [CW-1:0] col_next;
    logic [NS-1:0] mask_reg;
    logic [NS-1:0] mask_next;
    logic          v1_reg;
    logic          v1_next;
    logic          v2_reg;
    logic          v2_next;

    // Payload
    logic signed [DW-1:0] held_reg;
    logic signed [DW-1:0] sp1_reg;
    logic signed [DW-1:0] sp2_reg;
    ggv_pkg::ggv_pkt_t    slot0_reg;
    ggv_pkg::ggv_pkt_t    slot1_reg;
    ggv_pkg::ggv_pkt_t    slot2_reg;
    ggv_pkg::ggv_meta_t   meta1_reg;
    ggv_pkg::ggv_meta_t   meta1_next;
    ggv_pkg::ggv_meta_t   meta2_reg;

    // Combinational
    logic signed [DW-1:0] s32;
    logic signed [DW-1:0] n_last;
    logic signed [DW-1:0] n_prev;
    logic signed [DW-1:0] o_last;
    logic [EW-1:0]        gs_ext;
    logic [MW-1:0]        m;
    logic [MW-1:0]        m_last;
    logic [CW-1:0]        entry;
    logic                 pos_out;
    logic [CW-1:0]        r;
    logic [CW-1:0]        c;
    logic [MW-1:0]        c_inc;
    logic [MW-1:0]        r_inc;
    logic                 first_row;
    logic                 second_row;
    logic                 last_row;
    logic                 col_first;
    logic                 col_second;
    logic                 col_last;
    ggv_pkg::ggv_pkt_t    slot0;
    ggv_pkg::ggv_pkt_t    slot1;
    ggv_pkg::ggv_pkt_t    slot2;
    logic [NS-1:0]        new_mask;
    logic [NS-1:0]        emit_oh;
    logic [NS-1:0]        mask_after;
    ggv_pkg::ggv_pkt_t    sel_pkt;
    logic                 sel_last;
    logic                 accept;
    logic                 emit;
    logic                 adv1;
    logic                 adv2;
    logic                 load2;

    // ---------------- input sample ----------------
    if (SAMPLE_WIDTH <= DW) begin : g_sample_ext
        assign s32 = DW'(s_sample);
    end else begin : g_sample_sat
        logic [SAMPLE_WIDTH-DW:0] upper;
        assign upper = s_sample[SAMPLE_WIDTH-1:DW-1];
        assign s32 = ((&upper) || !(|upper)) ? s_sample[DW-1:0]
                   : (upper[SAMPLE_WIDTH-DW] ? ggv_pkg::SAT_MIN : ggv_pkg::SAT_MAX);
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg   <= ggv_pkg::GRID_SIZE_RESET;
            inv_spacing_reg <= ggv_pkg::INV_SPACING_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ggv_pkg::CFG_GRID_SIZE:   grid_size_reg   <= cfg_wdata[GW-1:0];
                ggv_pkg::CFG_INV_SPACING: inv_spacing_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- grid position ----------------
    always_comb begin
        gs_ext = EW'(grid_size_reg);
        if (gs_ext < EW'(ggv_pkg::GRID_MIN)) begin
            m = MW'(ggv_pkg::GRID_MIN);
        end else if (gs_ext > EW'(GRID_MAX)) begin
            m = MW'(GRID_MAX);
        end else begin
            m = MW'(gs_ext);
        end
        m_last = m - 1'b1;
        entry  = CW'(MW'(GRID_MAX) - m);

        // Restart the raster when the grid has shrunk under the position.
        pos_out = (MW'(row_reg) >= m) || (MW'(col_reg) >= m);
        r       = pos_out ? '0 : row_reg;
        c       = pos_out ? '0 : col_reg;

        first_row  = (r == '0);
        second_row = (MW'(r) == MW'(1));
        last_row   = (MW'(r) == m_last);
        col_first  = (c == '0);
        col_second = (MW'(c) == MW'(1));
        col_last   = (MW'(c) == m_last);

        c_inc = MW'(c) + 1'b1;
        r_inc = MW'(r) + 1'b1;
        if (c_inc >= m) begin
            col_next = '0;
            row_next = (r_inc >= m) ? '0 : CW'(r_inc);
        end else begin
            col_next = CW'(c_inc);
            row_next = r;
        end
    end

    // ---------------- line stores ----------------
    ggv_line #(.DEPTH(GRID_MAX)) u_line_newer (
        .aclk     (aclk),
        .shift_en (accept),
        .entry    (entry),
        .din      (s32),
        .tap_last (n_last),
        .tap_prev (n_prev)
    );

    ggv_line #(.DEPTH(GRID_MAX)) u_line_older (
        .aclk     (aclk),
        .shift_en (accept),
        .entry    (entry),
        .din      (n_last),
        .tap_last (o_last),
        .tap_prev ()
    );

    // ---------------- results of one request ----------------
    // Slot 0: point one row up. Slot 1: last row, one column left. Slot 2: final point.
    always_comb begin
        slot0.x = second_row ? ggv_pkg::diff_term(s32, n_last, 1'b0)
                             : ggv_pkg::diff_term(s32, o_last, 1'b1);
        if (col_first) begin
            slot0.y = ggv_pkg::diff_term(n_last, n_prev, 1'b0);
        end else if (col_last) begin
            slot0.y = ggv_pkg::diff_term(held_reg, n_last, 1'b0);
        end else begin
            slot0.y = ggv_pkg::diff_term(held_reg, n_prev, 1'b1);
        end
        slot0.meta.row  = XW'(r - 1'b1);
        slot0.meta.col  = XW'(c);
        slot0.meta.eof  = 1'b0;
        slot0.meta.last = 1'b0;

        slot1.x = ggv_pkg::diff_term(sp1_reg, held_reg, 1'b0);
        slot1.y = col_second ? ggv_pkg::diff_term(sp1_reg, s32, 1'b0)
                             : ggv_pkg::diff_term(sp2_reg, s32, 1'b1);
        slot1.meta.row  = XW'(r);
        slot1.meta.col  = XW'(c - 1'b1);
        slot1.meta.eof  = 1'b0;
        slot1.meta.last = 1'b0;

        slot2.x = ggv_pkg::diff_term(s32, n_last, 1'b0);
        slot2.y = ggv_pkg::diff_term(sp1_reg, s32, 1'b0);
        slot2.meta.row  = XW'(r);
        slot2.meta.col  = XW'(c);
        slot2.meta.eof  = 1'b1;
        slot2.meta.last = 1'b0;

        new_mask = {last_row && col_last, last_row && !col_first, !first_row};
    end

    // ---------------- issue and pipeline control ----------------
    always_comb begin
        adv2  = !v2_reg || m_ready;
        adv1  = !v1_reg || adv2;
        load2 = adv2 && v1_reg;

        if (mask_reg[0]) begin
            emit_oh = 3'b001;
            sel_pkt = slot0_reg;
        end else if (mask_reg[1]) begin
            emit_oh = 3'b010;
            sel_pkt = slot1_reg;
        end else begin
            emit_oh = mask_reg[2] ? 3'b100 : 3'b000;
            sel_pkt = slot2_reg;
        end
        emit     = (mask_reg != '0) && adv1;
        sel_last = ((mask_reg & ~emit_oh) == '0);

        meta1_next      = sel_pkt.meta;
        meta1_next.last = sel_last;

        mask_after = adv1 ? (mask_reg & ~emit_oh) : mask_reg;
        s_ready    = (mask_after == '0);
        accept     = s_valid && s_ready;
        mask_next  = accept ? new_mask : mask_after;

        v1_next = adv1 ? emit : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            mask_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            if (accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            mask_reg <= mask_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg  <= n_last;
            sp1_reg   <= s32;
            sp2_reg   <= sp1_reg;
            slot0_reg <= slot0;
            slot1_reg <= slot1;
            slot2_reg <= slot2;
        end
        if (emit) begin
            meta1_reg <= meta1_next;
        end
        if (load2) begin
            meta2_reg <= meta1_reg;
        end
    end

    // ---------------- scaling lanes ----------------
    ggv_scale u_scale_x (
        .aclk        (aclk),
        .load_mul    (emit),
        .load_out    (load2),
        .term        (sel_pkt.x),
        .inv_spacing (inv_spacing_reg),
        .vel         (m_vel_x)
    );

    ggv_scale u_scale_y (
        .aclk        (aclk),
        .load_mul    (emit),
        .load_out    (load2),
        .term        (sel_pkt.y),
        .inv_spacing (inv_spacing_reg),
        .vel         (m_vel_y)
    );

    assign m_valid        = v2_reg;
    assign m_row_index    = meta2_reg.row;
    assign m_col_index    = meta2_reg.col;
    assign m_end_of_frame = meta2_reg.eof;
    assign m_last_in_run  = meta2_reg.last;

`ifndef SYNTH
    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_last_in_run)
        else $error("end of frame without last in run");

    a_single_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ($countones(mask_reg) <= 1))
        else $error("request taken with more than one result pending");

    a_emit_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> v1_reg)
        else $error("issued result lost before the multiply stage");

    a_eof_slot_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && new_mask[2] |-> new_mask[1])
        else $error("final point issued without its left neighbour");
`endif

endmodule

`default_nettype wire
